// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and widths for the preemptive priority schedule simulator.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 8;
  localparam int PRI_W  = 8;
  localparam int TICK_W = 17;
  localparam int SUM_W  = 23;
  localparam int IDX_W  = 6;

  // One process entry of the table
  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [PRI_W-1:0]  prio;
    logic [BUR_W-1:0]  remaining;
    logic [TICK_W-1:0] first_start;
    logic [TICK_W-1:0] finish;
    logic              started;
  } proc_rec_t;

  // Control from the sequencer to the pick unit
  typedef struct packed {
    logic clear;
    logic eval;
  } scan_ctl_t;

endpackage

// ===== hdl/pps_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_table
// Process table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_table
  import pps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  proc_rec_t     wdata,
  input  logic [AW-1:0] raddr,
  output proc_rec_t     rdata
);

  proc_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pps_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pick
// Shared compare unit: takes one table entry per cycle during a tick scan
// and keeps the best ready process and the earliest future arrival.
// ----------------------------------------------------------------------------
module pps_pick
  import pps_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [AW-1:0]     idx,
  input  proc_rec_t         rec,
  input  logic [TICK_W-1:0] tick,
  output logic              found,
  output logic [AW-1:0]     pick_idx,
  output proc_rec_t         pick_rec,
  output logic [TICK_W-1:0] next_arr
);

  logic [TICK_W-1:0] arr_ext;
  logic              live;
  logic              arrived;
  logic              better;
  logic              sooner;

  assign arr_ext = {1'b0, rec.arrival};
  assign live    = (rec.remaining != '0);
  assign arrived = (arr_ext <= tick);
  assign better  = !found || (rec.prio < pick_rec.prio);
  assign sooner  = (arr_ext < next_arr);

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      next_arr <= '1;
    end else if (ctl.clear) begin
      found    <= 1'b0;
      next_arr <= '1;
    end else if (ctl.eval && live) begin
      if (arrived) begin
        // strict compare keeps the lowest index on ties
        if (better) begin
          found    <= 1'b1;
          pick_idx <= idx;
          pick_rec <= rec;
        end
      end else if (sooner) begin
        next_arr <= arr_ext;
      end
    end
  end

endmodule

// ===== hdl/preemptive_priority_schedule_sim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_schedule_sim
// Tick-by-tick preemptive priority scheduler with per-process metrics.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one process per transfer, one per cycle
// while loading. Up to MAX_PROCS processes are stored; extra ones are dropped.
// A transfer with final_process set closes the set and starts the schedule;
// in_ready stays low until the last result has been taken.
// Each simulated tick is one scan of the process table through its single
// read port. A run of idle ticks costs one scan, since the tick counter
// jumps to the next arrival.
// Output channel (out_valid/out_ready): one result per process in index
// order, each read from the table, computed and then held until taken; a
// stalled receiver holds the result and the block waits. The sums and
// last_result are set on the final result only.
// Reset returns the block to loading with an empty set; the table needs no
// clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module preemptive_priority_schedule_sim
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ARR_W-1:0]    arrival_time,
  input  logic [BUR_W-1:0]    burst_time,
  input  logic [PRI_W-1:0]    priority_level,
  input  logic                final_process,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    process_index,
  output logic [TICK_W-1:0]   waiting_time,
  output logic [TICK_W-1:0]   turnaround_time,
  output logic [TICK_W-1:0]   response_time,
  output logic [SUM_W-1:0]    sum_waiting,
  output logic [SUM_W-1:0]    sum_turnaround,
  output logic [SUM_W-1:0]    sum_response,
  output logic                last_result
);

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_DRAIN    = 7'b0000100,
    S_UPDATE   = 7'b0001000,
    S_OUT_RD   = 7'b0010000,
    S_OUT_CALC = 7'b0100000,
    S_OUT_HOLD = 7'b1000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     loaded;
  logic [CW-1:0]     n_total;
  logic [CW-1:0]     done;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     eval_idx;
  logic              eval_vld;
  logic [TICK_W-1:0] tick;
  logic [SUM_W-1:0]  acc_w;
  logic [SUM_W-1:0]  acc_t;
  logic [SUM_W-1:0]  acc_r;

  logic              full;
  logic              load_go;
  logic              rd_last;
  logic [BUR_W-1:0]  bur_fix;
  proc_rec_t         load_rec;
  proc_rec_t         upd_rec;
  proc_rec_t         rd_data;
  logic              we;
  logic [AW-1:0]     waddr;
  proc_rec_t         wdata;
  scan_ctl_t         scan_ctl;
  logic              found;
  logic [AW-1:0]     pick_idx;
  proc_rec_t         pick_rec;
  logic [TICK_W-1:0] next_arr;
  logic              pick_ends;

  logic [TICK_W-1:0] tat;
  logic [TICK_W-1:0] wt;
  logic [TICK_W-1:0] rt;
  logic [SUM_W-1:0]  acc_w_next;
  logic [SUM_W-1:0]  acc_t_next;
  logic [SUM_W-1:0]  acc_r_next;

  assign in_ready  = (state == S_LOAD);
  assign load_go   = in_valid && in_ready;
  assign full      = (loaded == CW'(MAX_PROCS));
  assign rd_last   = (CW'(rd_addr) == (n_total - CW'(1)));
  assign bur_fix   = (burst_time == '0) ? BUR_W'(1) : burst_time;
  assign pick_ends = (pick_rec.remaining == BUR_W'(1));

  always_comb begin
    load_rec             = '0;
    load_rec.arrival     = arrival_time;
    load_rec.burst       = bur_fix;
    load_rec.prio        = priority_level;
    load_rec.remaining   = bur_fix;
  end

  // Serve the picked process for one tick
  always_comb begin
    upd_rec           = pick_rec;
    upd_rec.remaining = pick_rec.remaining - BUR_W'(1);
    if (!pick_rec.started) begin
      upd_rec.started     = 1'b1;
      upd_rec.first_start = tick;
    end
    if (pick_ends) begin
      upd_rec.finish = tick + TICK_W'(1);
    end
  end

  assign we    = (load_go && !full) || ((state == S_UPDATE) && found);
  assign waddr = (state == S_UPDATE) ? pick_idx : loaded[AW-1:0];
  assign wdata = (state == S_UPDATE) ? upd_rec : load_rec;

  assign scan_ctl.clear = (state == S_LOAD) || (state == S_UPDATE);
  assign scan_ctl.eval  = eval_vld;

  pps_table #(
    .DEPTH (MAX_PROCS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pps_pick #(
    .AW (AW)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .idx      (eval_idx),
    .rec      (rd_data),
    .tick     (tick),
    .found    (found),
    .pick_idx (pick_idx),
    .pick_rec (pick_rec),
    .next_arr (next_arr)
  );

  assign tat        = rd_data.finish - {1'b0, rd_data.arrival};
  assign wt         = tat - TICK_W'(rd_data.burst);
  assign rt         = rd_data.first_start - {1'b0, rd_data.arrival};
  assign acc_w_next = acc_w + SUM_W'(wt);
  assign acc_t_next = acc_t + SUM_W'(tat);
  assign acc_r_next = acc_r + SUM_W'(rt);

  always_ff @(posedge clk) begin
    eval_idx <= rd_addr;
    if (rst) begin
      state     <= S_LOAD;
      loaded    <= '0;
      done      <= '0;
      tick      <= '0;
      rd_addr   <= '0;
      eval_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      eval_vld <= (state == S_SCAN);
      unique case (state)
        S_LOAD: begin
          if (load_go) begin
            if (!full) begin
              loaded <= loaded + CW'(1);
            end
            if (final_process) begin
              n_total <= full ? loaded : loaded + CW'(1);
              done    <= '0;
              tick    <= '0;
              rd_addr <= '0;
              acc_w   <= '0;
              acc_t   <= '0;
              acc_r   <= '0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_last) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          rd_addr <= '0;
          state   <= S_SCAN;
          if (found) begin
            tick <= tick + TICK_W'(1);
            if (pick_ends) begin
              done <= done + CW'(1);
              if ((done + CW'(1)) == n_total) begin
                state <= S_OUT_RD;
              end
            end
          end else begin
            // skip the idle stretch
            tick <= next_arr;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CALC;
        end
        S_OUT_CALC: begin
          process_index   <= IDX_W'(rd_addr);
          waiting_time    <= wt;
          turnaround_time <= tat;
          response_time   <= rt;
          acc_w           <= acc_w_next;
          acc_t           <= acc_t_next;
          acc_r           <= acc_r_next;
          sum_waiting     <= rd_last ? acc_w_next : '0;
          sum_turnaround  <= rd_last ? acc_t_next : '0;
          sum_response    <= rd_last ? acc_r_next : '0;
          last_result     <= rd_last;
          out_valid       <= 1'b1;
          state           <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (rd_last) begin
              loaded <= '0;
              done   <= '0;
              tick   <= '0;
              state  <= S_LOAD;
            end else begin
              rd_addr <= rd_addr + AW'(1);
              state   <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) || (done <= n_total))
    else $error("finished count exceeds process count");

  a_tick_adv: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UPDATE) && found) |=> (tick == $past(tick) + TICK_W'(1)))
    else $error("served tick did not advance time by one");

  a_last_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result) |-> (sum_turnaround != '0))
    else $error("final result carries an empty turnaround sum");

endmodule

// ===== test/preemptive_priority_schedule_sim_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_schedule_sim_tb
// Loads process sets through the input channel and checks the per-process
// waiting, turnaround and response times, and the closing sums, against a
// tick-by-tick schedule worked out in the bench. Short directed sets come
// first, then random sets under three idling mixes, with one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module preemptive_priority_schedule_sim_tb;
  import pps_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic             closes_set;
  } proc_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] waiting;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] response;
    logic [SUM_W-1:0]  sum_w;
    logic [SUM_W-1:0]  sum_t;
    logic [SUM_W-1:0]  sum_r;
    logic              is_last;
  } proc_metrics_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [ARR_W-1:0]  arrival_time   = '0;
  logic [BUR_W-1:0]  burst_time     = '0;
  logic [PRI_W-1:0]  priority_level = '0;
  logic              final_process  = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [IDX_W-1:0]  process_index;
  logic [TICK_W-1:0] waiting_time;
  logic [TICK_W-1:0] turnaround_time;
  logic [TICK_W-1:0] response_time;
  logic [SUM_W-1:0]  sum_waiting;
  logic [SUM_W-1:0]  sum_turnaround;
  logic [SUM_W-1:0]  sum_response;
  logic              last_result;

  proc_item_t    pending_procs[$];
  proc_metrics_t expected_metrics[$];
  proc_item_t    next_proc;

  // Process table as the bench sees it
  int unsigned slot_arrival[NUM_SLOTS];
  int unsigned slot_burst[NUM_SLOTS];
  int unsigned slot_prio[NUM_SLOTS];
  int          loaded_procs = 0;

  int error_count    = 0;
  int send_gap_pct   = 19;
  int recv_stall_pct = 55;
  int hold_req_num   = 0;
  int hold_seen_num  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  preemptive_priority_schedule_sim #(
    .MAX_PROCS(NUM_SLOTS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .arrival_time   (arrival_time),
    .burst_time     (burst_time),
    .priority_level (priority_level),
    .final_process  (final_process),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .process_index  (process_index),
    .waiting_time   (waiting_time),
    .turnaround_time(turnaround_time),
    .response_time  (response_time),
    .sum_waiting    (sum_waiting),
    .sum_turnaround (sum_turnaround),
    .sum_response   (sum_response),
    .last_result    (last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int idx, longint unsigned got,
                             longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("process %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  // Run the loaded set tick by tick and queue one metrics record per process.
  function automatic void schedule_set();
    int unsigned   tick;
    int unsigned   served;
    int unsigned   next_arr;
    int unsigned   tat;
    int unsigned   wt;
    int unsigned   rt;
    int unsigned   sw;
    int unsigned   st;
    int unsigned   sr;
    int            pick;
    int unsigned   left[NUM_SLOTS];
    int unsigned   first_run[NUM_SLOTS];
    int unsigned   finish[NUM_SLOTS];
    bit            ran[NUM_SLOTS];
    proc_metrics_t m;
    tick   = 0;
    served = 0;
    sw     = 0;
    st     = 0;
    sr     = 0;
    for (int i = 0; i < loaded_procs; i++) begin
      left[i] = slot_burst[i];
      ran[i]  = 1'b0;
    end
    while (served < loaded_procs) begin
      pick     = -1;
      next_arr = 32'hFFFF_FFFF;
      for (int i = 0; i < loaded_procs; i++) begin
        if (left[i] != 0) begin
          if (slot_arrival[i] <= tick) begin
            if (pick < 0 || slot_prio[i] < slot_prio[pick]) pick = i;
          end else if (slot_arrival[i] < next_arr) begin
            next_arr = slot_arrival[i];
          end
        end
      end
      // skip an idle stretch to the next arrival
      if (pick < 0) begin
        tick = next_arr;
      end else begin
        if (!ran[pick]) begin
          ran[pick]       = 1'b1;
          first_run[pick] = tick;
        end
        left[pick]--;
        tick++;
        if (left[pick] == 0) begin
          finish[pick] = tick;
          served++;
        end
      end
    end
    for (int i = 0; i < loaded_procs; i++) begin
      tat = (finish[i] - slot_arrival[i]) & 32'h1FFFF;
      wt  = (tat - slot_burst[i]) & 32'h1FFFF;
      rt  = (first_run[i] - slot_arrival[i]) & 32'h1FFFF;
      sw += wt;
      st += tat;
      sr += rt;
      m            = '0;
      m.idx        = IDX_W'(i);
      m.waiting    = TICK_W'(wt);
      m.turnaround = TICK_W'(tat);
      m.response   = TICK_W'(rt);
      if (i == loaded_procs - 1) begin
        m.sum_w   = SUM_W'(sw);
        m.sum_t   = SUM_W'(st);
        m.sum_r   = SUM_W'(sr);
        m.is_last = 1'b1;
      end
      expected_metrics.push_back(m);
    end
    loaded_procs = 0;
  endfunction

  task automatic push_proc(int arr, int bur, int pri, bit fin);
    proc_item_t it;
    it.arrival    = ARR_W'(arr);
    it.burst      = BUR_W'(bur);
    it.prio       = PRI_W'(pri);
    it.closes_set = fin;
    pending_procs.push_back(it);
  endtask

  // Mostly short sets with short bursts, some full and oversized sets,
  // and now and then a long burst or a far arrival.
  task automatic queue_random_sets(int n_items);
    int         sent;
    int         set_len;
    int         roll;
    proc_item_t it;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 70) set_len = $urandom_range(1, 6);
      else if (roll < 92) set_len = $urandom_range(7, 16);
      else set_len = $urandom_range(17, 20);
      for (int k = 0; k < set_len; k++) begin
        it.arrival    = ARR_W'(($urandom_range(7) == 0) ? $urandom : $urandom_range(63));
        it.burst      = BUR_W'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                         : $urandom_range(1, 16));
        it.prio       = PRI_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(7));
        it.closes_set = (k == set_len - 1);
        pending_procs.push_back(it);
      end
      sent += set_len;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_procs.size() != 0 || in_valid || expected_metrics.size() != 0)
      @(negedge clk);
  endtask

  // Sender: advance to the next process once the current one transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_procs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_proc = pending_procs.pop_front();
        in_valid       <= 1'b1;
        arrival_time   <= next_proc.arrival;
        burst_time     <= next_proc.burst;
        priority_level <= next_proc.prio;
        final_process  <= next_proc.closes_set;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen_num != hold_req_num) begin
      hold_seen_num <= hold_req_num;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: record loaded processes, check each result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        // drop processes past the table size, but honor their final bit
        if (loaded_procs < NUM_SLOTS) begin
          slot_arrival[loaded_procs] = 32'(arrival_time);
          slot_burst[loaded_procs]   = (burst_time == '0) ? 32'd1 : 32'(burst_time);
          slot_prio[loaded_procs]    = 32'(priority_level);
          loaded_procs++;
        end
        if (final_process) schedule_set();
      end
      if (out_valid && out_ready) begin
        if (expected_metrics.size() == 0) begin
          report_mismatch($sformatf("unexpected result for process %0d", process_index));
        end else begin
          proc_metrics_t m;
          m = expected_metrics.pop_front();
          check_field("index", int'(m.idx), 64'(process_index), 64'(m.idx));
          check_field("waiting", int'(m.idx), 64'(waiting_time), 64'(m.waiting));
          check_field("turnaround", int'(m.idx), 64'(turnaround_time),
                      64'(m.turnaround));
          check_field("response", int'(m.idx), 64'(response_time), 64'(m.response));
          check_field("sum_waiting", int'(m.idx), 64'(sum_waiting), 64'(m.sum_w));
          check_field("sum_turnaround", int'(m.idx), 64'(sum_turnaround), 64'(m.sum_t));
          check_field("sum_response", int'(m.idx), 64'(sum_response), 64'(m.sum_r));
          check_field("last_result", int'(m.idx), 64'(last_result), 64'(m.is_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("preemptive_priority_schedule_sim_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single process, zero burst, highest priority
    push_proc(0, 0, 0, 1'b1);
    // latest arrival, longest burst, lowest priority
    push_proc(65535, 255, 255, 1'b1);
    // equal priority and arrival: lowest index wins
    push_proc(2, 3, 4, 1'b0);
    push_proc(2, 3, 4, 1'b0);
    push_proc(2, 3, 4, 1'b1);
    // later, more urgent arrival preempts a running process
    push_proc(0, 10, 5, 1'b0);
    push_proc(3, 2, 1, 1'b0);
    push_proc(4, 1, 5, 1'b1);
    // full table of long bursts, one extra process dropped but closing the set
    for (int k = 0; k < NUM_SLOTS; k++)
      push_proc(k * 7, 255, (k * 37) % 256, 1'b0);
    push_proc(12, 9, 0, 1'b1);
    wait_drained();

    queue_random_sets(130);
    wait_drained();

    send_gap_pct   = 55;
    recv_stall_pct = 19;
    queue_random_sets(130);
    wait_drained();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req_num++;
    queue_random_sets(140);
    wait_drained();

    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("preemptive_priority_schedule_sim_tb: clean");
    end else begin
      $display("preemptive_priority_schedule_sim_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_table.sv
hdl/pps_pick.sv
hdl/preemptive_priority_schedule_sim.sv
test/preemptive_priority_schedule_sim_tb.sv
